[rtl/dmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the dynamic matrix control step block.
// ----------------------------------------------------------------------------
package dmc_pkg;

    // Default sizing
    localparam int DMC_HORIZON  = 30;
    localparam int DMC_SAMPLE_W = 16;

    // Fixed formats
    localparam int COEF_IDX_W = 5;   // width of the coefficient slot field
    localparam int FRAC_BITS  = 12;  // Q4.12 fraction bits
    localparam int DIGIT_W    = 8;   // multiplier digit consumed per cycle

    // Operation codes carried on tuser of the input stream
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_CLIP,
        ST_SUM,
        ST_DONE
    } t_state;

    // Control into the digit-serial multiply-accumulate unit
    typedef struct packed {
        logic load;   // take new operands, start a term
        logic clear;  // zero the accumulator
    } t_mac_ctl;

    // Status out of the multiply-accumulate unit
    typedef struct packed {
        logic busy;   // digits of a term still being consumed
        logic last;   // final digit of the current term this cycle
    } t_mac_sts;

    // Control into a register ring
    typedef struct packed {
        logic rotate; // step every entry one place towards the tap
        logic push;   // shift in a new entry at the tap, drop the oldest
        logic write;  // write one addressed entry
    } t_ring_ctl;

endpackage

[rtl/dmc_ring.sv]
// ----------------------------------------------------------------------------
// dmc_ring
// Register ring with a single read tap at entry 0. It rotates one entry per
// cycle to present each element at the tap in turn, takes addressed writes
// and can push a new entry in at the tap.
// ----------------------------------------------------------------------------
module dmc_ring #(
    parameter int DEPTH = dmc_pkg::DMC_HORIZON,
    parameter int WIDTH = dmc_pkg::DMC_SAMPLE_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dmc_pkg::t_ring_ctl               i_ctl,
    input  logic [dmc_pkg::COEF_IDX_W-1:0]   i_wr_idx,
    input  logic [WIDTH-1:0]                 i_wr_data,
    output logic [WIDTH-1:0]                 o_tap
);
    import dmc_pkg::*;

    logic [WIDTH-1:0] r_q [DEPTH];

    // Ring storage: rotate, push or addressed write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_q[i] <= '0;
            end
        end else if (i_ctl.rotate) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
            r_q[DEPTH-1] <= r_q[0];
        end else if (i_ctl.push) begin
            for (int i = DEPTH - 1; i > 0; i--) begin
                r_q[i] <= r_q[i-1];
            end
            r_q[0] <= i_wr_data;
        end else if (i_ctl.write) begin
            // slots beyond the ring never match
            for (int i = 0; i < DEPTH; i++) begin
                if (int'(i_wr_idx) == i) begin
                    r_q[i] <= i_wr_data;
                end
            end
        end
    end

    assign o_tap = r_q[0];

endmodule

[rtl/dmc_mac.sv]
// ----------------------------------------------------------------------------
// dmc_mac
// Digit-serial signed multiply-accumulate. The multiplier sits in a shift
// register and is consumed one digit per cycle, least significant first; the
// top digit is signed. Each partial product is aligned and added into a wide
// accumulator. A new term may be loaded in the cycle of the last digit.
// ----------------------------------------------------------------------------
module dmc_mac #(
    parameter int SAMPLE_WIDTH = dmc_pkg::DMC_SAMPLE_W,
    parameter int ACC_W        = 2 * dmc_pkg::DMC_SAMPLE_W + 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dmc_pkg::t_mac_ctl        i_ctl,
    input  logic signed [SAMPLE_WIDTH:0] i_mcand,
    input  logic signed [SAMPLE_WIDTH:0] i_mplier,
    output dmc_pkg::t_mac_sts        o_sts,
    output logic signed [ACC_W-1:0]  o_acc
);
    import dmc_pkg::*;

    localparam int MC_W     = SAMPLE_WIDTH + 1;
    localparam int N_DIGITS = (MC_W + DIGIT_W - 1) / DIGIT_W;
    localparam int XW       = N_DIGITS * DIGIT_W;
    localparam int CNT_W    = $clog2(N_DIGITS);
    localparam int SH_W     = $clog2(XW);

    logic signed [MC_W-1:0]    r_mcand;
    logic [XW-1:0]             r_mplier;
    logic [CNT_W-1:0]          r_digit;
    logic [SH_W-1:0]           r_shamt;
    logic                      r_busy;
    logic signed [ACC_W-1:0]   r_acc;

    logic                      last_digit;
    logic signed [DIGIT_W:0]   digit_s;
    logic signed [MC_W+DIGIT_W:0] pp;
    logic signed [ACC_W-1:0]   pp_sh;

    // Current digit: unsigned except the most significant one
    assign last_digit = (r_digit == CNT_W'(N_DIGITS - 1));
    assign digit_s    = {last_digit & r_mplier[DIGIT_W-1], r_mplier[DIGIT_W-1:0]};
    assign pp         = r_mcand * digit_s;
    assign pp_sh      = ACC_W'(pp) <<< r_shamt;

    // Digit sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_digit <= '0;
        end else if (i_ctl.load) begin
            r_busy  <= 1'b1;
            r_digit <= '0;
        end else if (r_busy) begin
            if (last_digit) begin
                r_busy  <= 1'b0;
                r_digit <= '0;
            end else begin
                r_digit <= r_digit + 1'b1;
            end
        end
    end

    // Operand shift register and alignment
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand  <= i_mcand;
            r_mplier <= XW'(i_mplier);
            r_shamt  <= '0;
        end else if (r_busy) begin
            r_mplier <= r_mplier >> DIGIT_W;
            r_shamt  <= r_shamt + SH_W'(DIGIT_W);
        end
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.last = r_busy & last_digit;
    assign o_acc      = r_acc;

endmodule

[rtl/dmc_control_step.sv]
// ----------------------------------------------------------------------------
// dmc_control_step
// Online dynamic matrix control law, single input single output.
//
// Input stream (s_axis): tuser selects the operation. A load word writes one
// gain slot (slot 0 the error gain, slots 1..HORIZON-1 the past-increment
// gains); slots beyond the horizon are ignored. A sample word carries the
// measured output and setpoint and yields one result word on m_axis holding
// the new control value, the applied increment and a saturation flag.
// Loads give no result.
// A sample is worked by the single multiply-accumulate unit, which takes
// one 8-bit multiplier digit per cycle, one gain term after another, while
// the gain and history rings step one entry per term.
// One sample is in work at a time; a finished result waits in the output
// register while the next word is taken, and a sample completes only once
// the output register is free, so a stalled receiver holds the block.
// Reset clears the gains, the increment history and the held control value;
// the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module dmc_control_step #(
    parameter  int DYNAMICS_HORIZON = dmc_pkg::DMC_HORIZON,
    parameter  int SAMPLE_WIDTH     = dmc_pkg::DMC_SAMPLE_W,
    localparam int IN_DATA_W  = ((dmc_pkg::COEF_IDX_W + 3 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // coef_index, coef_value, measured_output, setpoint
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // control_value, control_increment
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // saturated
    output logic                  m_axis_tuser
);
    import dmc_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ACC_W  = 2 * SW + $clog2(DYNAMICS_HORIZON) + 3;
    localparam int TERM_W = $clog2(DYNAMICS_HORIZON);
    localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));

    // Input word fields
    logic [COEF_IDX_W-1:0] coef_index;
    logic [SW-1:0]         coef_value;
    logic [SW-1:0]         measured_output;
    logic [SW-1:0]         setpoint;

    assign coef_index      = s_axis_tdata[COEF_IDX_W-1:0];
    assign coef_value      = s_axis_tdata[COEF_IDX_W +: SW];
    assign measured_output = s_axis_tdata[COEF_IDX_W + SW +: SW];
    assign setpoint        = s_axis_tdata[COEF_IDX_W + 2 * SW +: SW];

    t_state r_state, n_state;

    logic [TERM_W-1:0]       r_term;
    logic signed [ACC_W-1:0] r_round;
    logic [SW-1:0]           r_inc;
    logic [SW-1:0]           r_ctl;
    logic                    r_hit;
    logic [SW-1:0]           r_held;
    logic                    r_out_valid;
    logic [SW-1:0]           r_out_ctl;
    logic [SW-1:0]           r_out_inc;
    logic                    r_out_hit;

    t_mac_ctl  mac_ctl;
    t_mac_sts  mac_sts;
    t_ring_ctl gain_ctl;
    t_ring_ctl hist_ctl;

    logic signed [ACC_W-1:0] mac_acc;
    logic signed [SW:0]      mac_mcand;
    logic signed [SW:0]      mac_mplier;
    logic [SW-1:0]           gain_tap;
    logic [SW-1:0]           hist_tap;
    logic signed [SW:0]      err;
    logic                    term_last;
    logic                    out_free;
    logic                    commit;

    logic signed [ACC_W-1:0] acc_sh;
    logic [ACC_W-SW:0]       acc_hi;
    logic [SW-1:0]           inc_clip;
    logic                    inc_hit;
    logic [SW:0]             ctl_sum;
    logic                    ctl_ovf;
    logic [SW-1:0]           ctl_clip;
    logic [SW-1:0]           applied;

    // Gain table ring: slot 0 at the tap between samples
    dmc_ring #(
        .DEPTH (DYNAMICS_HORIZON),
        .WIDTH (SW)
    ) u_gain_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (gain_ctl),
        .i_wr_idx  (coef_index),
        .i_wr_data (coef_value),
        .o_tap     (gain_tap)
    );

    // Increment history ring: newest entry at the tap
    dmc_ring #(
        .DEPTH (DYNAMICS_HORIZON - 1),
        .WIDTH (SW)
    ) u_hist_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (hist_ctl),
        .i_wr_idx  ('0),
        .i_wr_data (applied),
        .o_tap     (hist_tap)
    );

    // Shared multiply-accumulate unit
    dmc_mac #(
        .SAMPLE_WIDTH (SW),
        .ACC_W        (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_mcand  (mac_mcand),
        .i_mplier (mac_mplier),
        .o_sts    (mac_sts),
        .o_acc    (mac_acc)
    );

    // Operand selection: error term first, then negated past-increment terms
    assign err        = $signed({setpoint[SW-1], setpoint})
                      - $signed({measured_output[SW-1], measured_output});
    assign mac_mcand  = (r_state == ST_IDLE) ? $signed({gain_tap[SW-1], gain_tap})
                                             : -$signed({gain_tap[SW-1], gain_tap});
    assign mac_mplier = (r_state == ST_IDLE) ? err
                                             : $signed({hist_tap[SW-1], hist_tap});

    assign term_last = (r_term == TERM_W'(DYNAMICS_HORIZON - 1));
    assign out_free  = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tuser == OP_SAMPLE) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (mac_sts.last && term_last) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: n_state = ST_CLIP;
            ST_CLIP:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mac_ctl       = '0;
        gain_ctl      = '0;
        hist_ctl      = '0;
        commit        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_LOAD) begin
                        gain_ctl.write = 1'b1;
                    end else begin
                        mac_ctl.load    = 1'b1;
                        mac_ctl.clear   = 1'b1;
                        gain_ctl.rotate = 1'b1;
                    end
                end
            end
            ST_MAC: begin
                if (mac_sts.last && !term_last) begin
                    mac_ctl.load    = 1'b1;
                    gain_ctl.rotate = 1'b1;
                    hist_ctl.rotate = 1'b1;
                end
            end
            ST_DONE: begin
                commit        = out_free;
                hist_ctl.push = out_free;
            end
            default: begin
                commit = 1'b0;
            end
        endcase
    end

    // State register and term counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_term <= '0;
            end else if (mac_ctl.load) begin
                r_term <= r_term + 1'b1;
            end
        end
    end

    // Scale back to Q4.12 and clip the increment
    assign acc_sh   = r_round >>> FRAC_BITS;
    assign acc_hi   = acc_sh[ACC_W-1:SW-1];
    assign inc_hit  = !((&acc_hi) || !(|acc_hi));
    assign inc_clip = !inc_hit ? acc_sh[SW-1:0]
                    : (acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX);

    // Add to the held value and clip
    assign ctl_sum  = {r_held[SW-1], r_held} + {r_inc[SW-1], r_inc};
    assign ctl_ovf  = ctl_sum[SW] ^ ctl_sum[SW-1];
    assign ctl_clip = !ctl_ovf ? ctl_sum[SW-1:0]
                    : (ctl_sum[SW] ? SAT_MIN : SAT_MAX);

    // Increment actually applied
    assign applied = r_ctl - r_held;

    // Post-processing pipeline
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_ROUND: r_round <= mac_acc + ROUND_HALF;
            ST_CLIP: begin
                r_inc <= inc_clip;
                r_hit <= inc_hit;
            end
            ST_SUM: begin
                r_ctl <= ctl_clip;
                r_hit <= r_hit | ctl_ovf;
            end
            default: r_round <= r_round;
        endcase
    end

    // Held control value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (commit) begin
            r_held <= r_ctl;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_ctl <= r_ctl;
            r_out_inc <= applied;
            r_out_hit <= r_hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_inc, r_out_ctl});
    assign m_axis_tuser  = r_out_hit;

    // The multiply-accumulate unit only runs inside the term sequence
    a_mac_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_sts.busy |-> r_state == ST_MAC)
        else $error("multiply-accumulate busy outside the term sequence");

    // A new term is only loaded on the last digit of the previous one
    a_load_on_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC && mac_ctl.load) |-> mac_sts.last)
        else $error("term loaded before the previous term finished");

    // The term sequence ends only after the final term
    a_seq_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(mac_sts.busy) |-> (r_state == ST_ROUND && $past(term_last)))
        else $error("term sequence ended early");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !m_axis_tready) |=> r_state == ST_DONE)
        else $error("sample completed over a waiting result");

    // Results come only from a completed sample
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result word without a completed sample");

endmodule

[test/dmc_control_step_test.sv]
// ----------------------------------------------------------------------------
// dmc_control_step_test
// Self-checking bench for the dynamic matrix control step block. A directed
// table covers reset state, the extremes of every field, ignored loads and
// rounding and clipping, then random loads and samples run through four
// handshake phases. Every result word is checked against its table row or
// against a local model of the control law.
// ----------------------------------------------------------------------------
module dmc_control_step_test;

    import dmc_pkg::*;

    localparam int HORIZON    = DMC_HORIZON;
    localparam int SW         = DMC_SAMPLE_W;
    localparam int IN_W       = ((COEF_IDX_W + 3 * SW + 7) / 8) * 8;
    localparam int OUT_W      = ((2 * SW + 7) / 8) * 8;
    localparam int SAMPLE_LAT = HORIZON * ((SW + 1 + DIGIT_W - 1) / DIGIT_W) + 5;
    localparam int PHASE_ITEMS = 170;
    localparam int CYCLE_LIMIT = 500000;
    localparam longint Q_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint Q_MIN = -(longint'(1) <<< (SW - 1));

    // Expected result word
    typedef struct packed {
        logic signed [SW-1:0] ctl;
        logic signed [SW-1:0] inc;
        logic                 sat;
    } t_ctl_result;

    // One row of the directed table
    typedef struct packed {
        logic                         op;
        logic [COEF_IDX_W-1:0]        idx;
        logic signed [SW-1:0]         val;
        logic signed [SW-1:0]         meas;
        logic signed [SW-1:0]         sp;
        logic                         typed;  // result given in the row itself
        t_ctl_result                  res;
    } t_stim_row;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // coef_index, coef_value, measured_output, setpoint
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    // operation
    logic             s_axis_tuser  = OP_LOAD;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // control_value, control_increment
    logic [OUT_W-1:0] m_axis_tdata;
    // saturated
    logic             m_axis_tuser;

    // Model state of the control law
    logic signed [SW-1:0] gain_tab [HORIZON];
    logic signed [SW-1:0] inc_hist [HORIZON-1];
    logic signed [SW-1:0] held_ctl;

    t_ctl_result pending_results[$];
    t_stim_row   directed_tab[$];

    int cycle_cnt  = 0;
    int n_loads    = 0;
    int n_samples  = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Result handshake as seen mid-cycle
    logic             res_fire = 1'b0;
    logic [OUT_W-1:0] res_word = '0;
    logic             res_sat  = 1'b0;

    dmc_control_step i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Clip to the signed sample range, flag any clipping
    function automatic longint clip_q(input longint v, inout logic hit);
        if (v > Q_MAX) begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            hit = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // One control sample: error term less the weighted past increments
    task automatic control_law_step(input logic signed [SW-1:0] meas,
                                    input logic signed [SW-1:0] sp,
                                    output t_ctl_result res);
        longint err;
        longint acc;
        longint inc;
        longint ctl;
        logic   hit;
        int     j;
        hit = 1'b0;
        err = longint'(sp) - longint'(meas);
        acc = longint'(gain_tab[0]) * err;
        for (j = 1; j < HORIZON; j++)
            acc -= longint'(gain_tab[j]) * longint'(inc_hist[j-1]);
        // round half up, then floor shift back to Q4.12
        inc = clip_q((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS, hit);
        ctl = clip_q(longint'(held_ctl) + inc, hit);
        res.inc = SW'(ctl - longint'(held_ctl));
        res.ctl = SW'(ctl);
        res.sat = hit;
        for (j = HORIZON - 2; j > 0; j--)
            inc_hist[j] = inc_hist[j-1];
        inc_hist[0] = res.inc;
        held_ctl    = res.ctl;
    endtask

    function automatic t_stim_row stim_row(input logic op, input int idx, input int val,
                                           input int meas, input int sp, input logic typed,
                                           input int ctl, input int inc, input logic sat);
        t_stim_row r;
        r.op    = op;
        r.idx   = COEF_IDX_W'(idx);
        r.val   = SW'(val);
        r.meas  = SW'(meas);
        r.sp    = SW'(sp);
        r.typed = typed;
        r.res.ctl = SW'(ctl);
        r.res.inc = SW'(inc);
        r.res.sat = sat;
        return r;
    endfunction

    // Present one word, wait for it to be taken, then update the model
    task automatic send_word(input t_stim_row r);
        logic [IN_W-1:0] word;
        logic            taken;
        t_ctl_result     pred;
        word = '0;
        word[COEF_IDX_W + 3*SW - 1:0] = {r.sp, r.meas, r.val, r.idx};
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= r.op;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end
        if (r.op == OP_LOAD) begin
            n_loads++;
            if (r.idx < HORIZON)
                gain_tab[r.idx] = r.val;
        end else begin
            n_samples++;
            control_law_step(r.meas, r.sp, pred);
            pending_results.push_back(r.typed ? r.res : pred);
        end
    endtask

    // Random word: mostly moderate gains and signals, some full-range values
    task automatic send_random_word();
        t_stim_row r;
        r = '0;
        r.op  = ($urandom_range(99) < 35) ? OP_LOAD : OP_SAMPLE;
        r.idx = ($urandom_range(15) == 0) ? COEF_IDX_W'($urandom_range(31, HORIZON))
                                          : COEF_IDX_W'($urandom_range(HORIZON - 1));
        if ($urandom_range(7) == 0)
            r.val = SW'($urandom);
        else if (r.idx == 0)
            r.val = SW'(int'($urandom_range(16384)) - 8192);
        else
            r.val = SW'(int'($urandom_range(2048)) - 1024);
        r.meas = ($urandom_range(7) == 0) ? SW'($urandom)
                                          : SW'(int'($urandom_range(8192)) - 4096);
        r.sp   = ($urandom_range(7) == 0) ? SW'($urandom)
                                          : SW'(int'($urandom_range(8192)) - 4096);
        send_word(r);
    endtask

    // Mid-cycle snapshot of the result handshake
    always @(negedge i_clk) begin
        res_fire = m_axis_tvalid && m_axis_tready && i_rst_n;
        res_word = m_axis_tdata;
        res_sat  = m_axis_tuser;
    end

    // Receiver: random stall, compare each taken word with the oldest expectation
    always @(posedge i_clk) begin
        t_ctl_result want;
        t_ctl_result got;
        cycle_cnt <= cycle_cnt + 1;
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        if (res_fire) begin
            got.ctl = res_word[SW-1:0];
            got.inc = res_word[2*SW-1:SW];
            got.sat = res_sat;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result word ctl=%0d inc=%0d sat=%0b",
                         $time, got.ctl, got.inc, got.sat);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.ctl !== want.ctl) begin
                    n_errors++;
                    $display("%0t: control_value expected %0d got %0d",
                             $time, want.ctl, got.ctl);
                end
                if (got.inc !== want.inc) begin
                    n_errors++;
                    $display("%0t: control_increment expected %0d got %0d",
                             $time, want.inc, got.inc);
                end
                if (got.sat !== want.sat) begin
                    n_errors++;
                    $display("%0t: saturated expected %0b got %0b",
                             $time, want.sat, got.sat);
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("%0t: cycle limit reached, %0d results outstanding",
                 $time, pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        int i;
        int ph;
        for (i = 0; i < HORIZON; i++)
            gain_tab[i] = '0;
        for (i = 0; i < HORIZON - 1; i++)
            inc_hist[i] = '0;
        held_ctl = '0;

        // reset state, extremes, clipping, ignored slots, rounding
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, -32768, 32767, 1'b1, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 0, 4096, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, 0, 1000, 1'b1, 1000, 1000, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 0, 32767, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, -32768, 32767, 1'b1,
                                        32767, 31767, 1'b1));
        directed_tab.push_back(stim_row(OP_LOAD, 0, -32768, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, -32768, 32767, 1'b1,
                                        -1, -32768, 1'b1));
        // slots past the horizon are dropped, the last slot is written
        directed_tab.push_back(stim_row(OP_LOAD, 31, 32767, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 30, -1, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 29, -32768, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 1, 4096, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0));
        // past increment alone drives the increment into the upper clip
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 1, 0, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 0, 2048, 0, 0, 1'b0, 0, 0, 1'b0));
        // exact halves: +0.5 rounds up, -0.5 rounds to zero
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, 0, 1, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, 1, 0, 1'b0, 0, 0, 1'b0));
        // large negative error: increment clip, then control clip
        directed_tab.push_back(stim_row(OP_LOAD, 0, 32767, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, 32767, -32768, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, 32767, -32768, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_LOAD, 0, 4096, 0, 0, 1'b0, 0, 0, 1'b0));
        directed_tab.push_back(stim_row(OP_SAMPLE, 0, 0, 100, -50, 1'b0, 0, 0, 1'b0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_tab[k])
            send_word(directed_tab[k]);

        // random words under each handshake pattern
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
                send_random_word();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * SAMPLE_LAT) @(posedge i_clk);

        $display("Covered %0d coefficient loads and %0d control samples, %0d results checked",
                 n_loads, n_samples, n_checked);
        $display("over four handshake phases, %0d mismatches", n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
